// ----- rtl/core/esc_telemetry_frame_decoder_macros.svh -----
`ifndef ESC_TELEMETRY_FRAME_DECODER_MACROS_SVH
`define ESC_TELEMETRY_FRAME_DECODER_MACROS_SVH

// Same-cycle check: consequent must hold in the cycle of the antecedent
`define ESCTFD_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |-> (cons)) else $error(msg);

// Next-cycle check: consequent must hold in the cycle after the antecedent
`define ESCTFD_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/esctfd_pkg.sv -----
package esctfd_pkg;

    // Frame constants
    localparam logic [7:0]  SYNC_BYTE      = 8'hA6;
    localparam logic [7:0]  TYPE_TELEM     = 8'h80;
    localparam logic [7:0]  DEVICE_ESC     = 8'h20;
    localparam logic [7:0]  FRAME_LEN_BYTE = 8'd22;
    localparam logic [7:0]  NO_DATA_8      = 8'hFF;
    localparam logic [15:0] NO_DATA_16     = 16'hFFFF;
    localparam logic [7:0]  THROTTLE_MAX   = 8'd200;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    // Byte counter: saturating 5-bit count, store keeps bytes 0..19
    localparam logic [4:0]  COUNT_MAX      = 5'd31;
    localparam logic [4:0]  LAST_POS       = 5'd21;
    localparam logic [4:0]  STORE_DEPTH    = 5'd20;
    localparam int          BODY_FIRST     = 3;
    localparam int          BODY_BYTES     = 17;

    // Queue occupancy (two entries)
    localparam logic [1:0]  Q_FULL_CNT     = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOT_ESC = 2'd2
    } t_status;

    // Classified frame: status plus bytes 3..19 (body[k] is frame byte k+3)
    typedef struct packed {
        t_status                    status;
        logic [BODY_BYTES-1:0][7:0] body;
    } t_frame_rec;

    // Decoded result word
    typedef struct packed {
        t_status     status;
        logic [15:0] device_ids;
        logic [19:0] electrical_rpm;
        logic [15:0] voltage_centivolts;
        logic [15:0] fet_temp_decidegrees;
        logic [15:0] current_centiamps;
        logic [15:0] bec_temp_decidegrees;
        logic [7:0]  bec_current_deciamps;
        logic [10:0] bec_voltage_centivolts;
        logic [7:0]  throttle_half_percent;
        logic [7:0]  power_out_half_percent;
        logic [8:0]  valid_mask;
    } t_result;

    // CRC-16 byte update, poly 0x1021, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/esctfd_front.sv -----
module esctfd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_data,
    input  logic                   i_last,
    input  logic                   i_q_full,
    output logic                   o_rec_push,
    output esctfd_pkg::t_frame_rec o_rec
);

`include "esc_telemetry_frame_decoder_macros.svh"

    logic [4:0]  r_count;
    logic [4:0]  n_count;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_store [0:19];
    logic        w_accept;
    logic        w_frame_ok;

    assign w_accept = i_push && !i_q_full;
    assign n_crc    = esctfd_pkg::crc_byte(r_crc, i_data);
    assign n_count  = (r_count == esctfd_pkg::COUNT_MAX) ? r_count : r_count + 5'd1;

    // Byte counter and running CRC, cleared at end of frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else if (w_accept) begin
            if (i_last) begin
                r_count <= '0;
                r_crc   <= '0;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
            end
        end
    end

    // Keep the first 20 bytes
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count < esctfd_pkg::STORE_DEPTH)) begin
            r_store[r_count] <= i_data;
        end
    end

    // Frame check: length, sync, type, length byte, CRC residue
    assign w_frame_ok = (r_count == esctfd_pkg::LAST_POS) &&
                        (r_store[0] == esctfd_pkg::SYNC_BYTE) &&
                        (r_store[1] == esctfd_pkg::TYPE_TELEM) &&
                        (r_store[2] == esctfd_pkg::FRAME_LEN_BYTE) &&
                        (n_crc == 16'h0000);

    // Classify and hand the body to the queue on the last byte
    always_comb begin
        if (!w_frame_ok) begin
            o_rec.status = esctfd_pkg::ST_INVALID;
        end else if (r_store[4] != esctfd_pkg::DEVICE_ESC) begin
            o_rec.status = esctfd_pkg::ST_NOT_ESC;
        end else begin
            o_rec.status = esctfd_pkg::ST_OK;
        end
        for (int k = 0; k < esctfd_pkg::BODY_BYTES; k++) begin
            o_rec.body[k] = r_store[k + esctfd_pkg::BODY_FIRST];
        end
    end

    assign o_rec_push = w_accept && i_last;

    `ESCTFD_ASSERT_NEXT(a_count_sat, w_accept && !i_last && (r_count == esctfd_pkg::COUNT_MAX), r_count == esctfd_pkg::COUNT_MAX, "byte count left saturation")
    `ESCTFD_ASSERT_NEXT(a_count_inc, w_accept && !i_last && (r_count != esctfd_pkg::COUNT_MAX), r_count == $past(r_count) + 5'd1, "byte count did not advance")
    `ESCTFD_ASSERT_NEXT(a_frame_clr, w_accept && i_last, (r_count == 5'd0) && (r_crc == 16'h0000), "frame state not cleared after last byte")

endmodule

// ----- rtl/core/esctfd_frame_q.sv -----
module esctfd_frame_q (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  esctfd_pkg::t_frame_rec i_rec,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output esctfd_pkg::t_frame_rec o_rec
);

    esctfd_pkg::t_frame_rec r_mem [0:1];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;

    assign o_full  = (r_cnt == esctfd_pkg::Q_FULL_CNT);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_mem[r_rptr];

    // Occupancy
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

// ----- rtl/core/esctfd_back.sv -----
module esctfd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  esctfd_pkg::t_frame_rec i_rec,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output esctfd_pkg::t_result    o_result
);

`include "esc_telemetry_frame_decoder_macros.svh"

    esctfd_pkg::t_result r_mem [0:1];
    esctfd_pkg::t_result n_res;
    logic                r_wptr;
    logic                r_rptr;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    logic                w_push;
    logic                w_pop;
    logic [15:0]         w_rpm;
    logic [15:0]         w_volt;
    logic [15:0]         w_fet;
    logic [15:0]         w_cur;
    logic [15:0]         w_bect;
    logic [7:0]          w_becc;
    logic [7:0]          w_becv;
    logic [7:0]          w_thr;
    logic [7:0]          w_pwr;

    // Move one classified frame per cycle into the result queue while the result queue has room
    assign w_push  = !i_q_empty && (r_cnt != esctfd_pkg::Q_FULL_CNT);
    assign o_q_pop = w_push;
    assign w_pop   = i_pop && !o_empty;

    // Raw fields (body[k] is frame byte k+3)
    assign w_rpm  = {i_rec.body[3],  i_rec.body[4]};
    assign w_volt = {i_rec.body[5],  i_rec.body[6]};
    assign w_fet  = {i_rec.body[7],  i_rec.body[8]};
    assign w_cur  = {i_rec.body[9],  i_rec.body[10]};
    assign w_bect = {i_rec.body[11], i_rec.body[12]};
    assign w_becc = i_rec.body[13];
    assign w_becv = i_rec.body[14];
    assign w_thr  = i_rec.body[15];
    assign w_pwr  = i_rec.body[16];

    // Decode with no-data sentinels and the throttle limit; all fields zero unless status is ok
    always_comb begin
        n_res        = '0;
        n_res.status = i_rec.status;
        if (i_rec.status == esctfd_pkg::ST_OK) begin
            n_res.device_ids = {i_rec.body[0], i_rec.body[2]};
            if (w_rpm != esctfd_pkg::NO_DATA_16) begin
                // rpm * 10 as (x << 3) + (x << 1)
                n_res.electrical_rpm = 20'({w_rpm, 3'b000}) + 20'({w_rpm, 1'b0});
                n_res.valid_mask[0]  = 1'b1;
            end
            if (w_volt != esctfd_pkg::NO_DATA_16) begin
                n_res.voltage_centivolts = w_volt;
                n_res.valid_mask[1]      = 1'b1;
            end
            if (w_fet != esctfd_pkg::NO_DATA_16) begin
                n_res.fet_temp_decidegrees = w_fet;
                n_res.valid_mask[2]        = 1'b1;
            end
            if (w_cur != esctfd_pkg::NO_DATA_16) begin
                n_res.current_centiamps = w_cur;
                n_res.valid_mask[3]     = 1'b1;
            end
            if (w_bect != esctfd_pkg::NO_DATA_16) begin
                n_res.bec_temp_decidegrees = w_bect;
                n_res.valid_mask[4]        = 1'b1;
            end
            if (w_becc != esctfd_pkg::NO_DATA_8) begin
                n_res.bec_current_deciamps = w_becc;
                n_res.valid_mask[5]        = 1'b1;
            end
            if (w_becv != esctfd_pkg::NO_DATA_8) begin
                // byte * 5 as (x << 2) + x
                n_res.bec_voltage_centivolts = 11'({w_becv, 2'b00}) + 11'(w_becv);
                n_res.valid_mask[6]          = 1'b1;
            end
            if (w_thr <= esctfd_pkg::THROTTLE_MAX) begin
                n_res.throttle_half_percent = w_thr;
                n_res.valid_mask[7]         = 1'b1;
            end
            if (w_pwr != esctfd_pkg::NO_DATA_8) begin
                n_res.power_out_half_percent = w_pwr;
                n_res.valid_mask[8]          = 1'b1;
            end
        end
    end

    // Result queue occupancy
    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= n_res;
        end
    end

    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rptr];

    `ESCTFD_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= esctfd_pkg::Q_FULL_CNT, "result queue overflow")
    `ESCTFD_ASSERT_NOW(a_bad_zero, w_push && (i_rec.status != esctfd_pkg::ST_OK), (n_res.valid_mask == 9'd0) && (n_res.device_ids == 16'd0) && (n_res.electrical_rpm == 20'd0), "fields not zero on bad frame")
    `ESCTFD_ASSERT_NOW(a_thr_zero, w_push && !n_res.valid_mask[7], n_res.throttle_half_percent == 8'd0, "invalid throttle not zeroed")

endmodule

// ----- rtl/core/esc_telemetry_frame_decoder.sv -----
// Telemetry frame decoder: one frame byte accepted per cycle while full is low.
// After its last byte is accepted, a result is written to the classified frame
// queue and then to the result queue, where it becomes poppable.
// full rises only when the two-entry frame queue holds two undrained frames.
// Synchronous active-low reset clears the byte counter, CRC and queue pointers;
// the 20-byte frame store is not cleared and needs no clearing pass.
module esc_telemetry_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [15:0] o_device_ids,
    output logic [19:0] o_electrical_rpm,
    output logic [15:0] o_voltage_centivolts,
    output logic [15:0] o_fet_temp_decidegrees,
    output logic [15:0] o_current_centiamps,
    output logic [15:0] o_bec_temp_decidegrees,
    output logic [7:0]  o_bec_current_deciamps,
    output logic [10:0] o_bec_voltage_centivolts,
    output logic [7:0]  o_throttle_half_percent,
    output logic [7:0]  o_power_out_half_percent,
    output logic [8:0]  o_valid_mask
);

    esctfd_pkg::t_frame_rec w_front_rec;
    esctfd_pkg::t_frame_rec w_back_rec;
    esctfd_pkg::t_result    w_result;
    logic                   w_rec_push;
    logic                   w_q_full;
    logic                   w_q_empty;
    logic                   w_q_pop;

    // Front: count, CRC, store, classify
    esctfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data_byte),
        .i_last     (i_last_byte),
        .i_q_full   (w_q_full),
        .o_rec_push (w_rec_push),
        .o_rec      (w_front_rec)
    );

    // Classified frame queue between front and back
    esctfd_frame_q u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_front_rec),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_rec   (w_back_rec)
    );

    // Back: field decode and result queue
    esctfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_rec     (w_back_rec),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (w_result)
    );

    assign full = w_q_full;

    // Result word onto ports
    assign o_status                 = w_result.status;
    assign o_device_ids             = w_result.device_ids;
    assign o_electrical_rpm         = w_result.electrical_rpm;
    assign o_voltage_centivolts     = w_result.voltage_centivolts;
    assign o_fet_temp_decidegrees   = w_result.fet_temp_decidegrees;
    assign o_current_centiamps      = w_result.current_centiamps;
    assign o_bec_temp_decidegrees   = w_result.bec_temp_decidegrees;
    assign o_bec_current_deciamps   = w_result.bec_current_deciamps;
    assign o_bec_voltage_centivolts = w_result.bec_voltage_centivolts;
    assign o_throttle_half_percent  = w_result.throttle_half_percent;
    assign o_power_out_half_percent = w_result.power_out_half_percent;
    assign o_valid_mask             = w_result.valid_mask;

endmodule

// ----- sim/tb.sv -----
module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_device_ids;
    logic [19:0] o_electrical_rpm;
    logic [15:0] o_voltage_centivolts;
    logic [15:0] o_fet_temp_decidegrees;
    logic [15:0] o_current_centiamps;
    logic [15:0] o_bec_temp_decidegrees;
    logic [7:0]  o_bec_current_deciamps;
    logic [10:0] o_bec_voltage_centivolts;
    logic [7:0]  o_throttle_half_percent;
    logic [7:0]  o_power_out_half_percent;
    logic [8:0]  o_valid_mask;

    // Decoder model state
    logic [4:0]  dec_count = '0;
    logic [15:0] dec_crc = '0;
    logic [7:0]  dec_store [20];

    // Decoded reports still owed by the block, oldest first
    esctfd_pkg::t_result pending_reports [$];

    // Frame under construction: bytes 0..19, CRC is appended on send
    logic [7:0]  frame_buf [20];

    int          fail_count = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          hold_left = 0;

    esc_telemetry_frame_decoder DUT (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .push                     (push),
        .full                     (full),
        .i_data_byte              (i_data_byte),
        .i_last_byte              (i_last_byte),
        .empty                    (empty),
        .pop                      (pop),
        .o_status                 (o_status),
        .o_device_ids             (o_device_ids),
        .o_electrical_rpm         (o_electrical_rpm),
        .o_voltage_centivolts     (o_voltage_centivolts),
        .o_fet_temp_decidegrees   (o_fet_temp_decidegrees),
        .o_current_centiamps      (o_current_centiamps),
        .o_bec_temp_decidegrees   (o_bec_temp_decidegrees),
        .o_bec_current_deciamps   (o_bec_current_deciamps),
        .o_bec_voltage_centivolts (o_bec_voltage_centivolts),
        .o_throttle_half_percent  (o_throttle_half_percent),
        .o_power_out_half_percent (o_power_out_half_percent),
        .o_valid_mask             (o_valid_mask)
    );

    always #2 i_clk = ~i_clk;

    // CRC-16 0x1021, MSB first, one data bit per step
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ esctfd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // Advance the decoder model by one accepted word; queue a report on the last byte
    function automatic void predict_telemetry(input logic [7:0] b, input logic last);
        logic [4:0]          pos;
        logic [15:0]         w;
        esctfd_pkg::t_result r;
        pos = dec_count;
        if (pos < esctfd_pkg::STORE_DEPTH) dec_store[pos] = b;
        dec_crc = crc16_update(dec_crc, b);
        if (dec_count != esctfd_pkg::COUNT_MAX) dec_count = dec_count + 5'd1;
        if (!last) return;

        r = '0;
        if (pos != esctfd_pkg::LAST_POS || dec_store[0] != esctfd_pkg::SYNC_BYTE ||
            dec_store[1] != esctfd_pkg::TYPE_TELEM ||
            dec_store[2] != esctfd_pkg::FRAME_LEN_BYTE || dec_crc != 16'h0000) begin
            r.status = esctfd_pkg::ST_INVALID;
        end else if (dec_store[4] != esctfd_pkg::DEVICE_ESC) begin
            r.status = esctfd_pkg::ST_NOT_ESC;
        end else begin
            r.status     = esctfd_pkg::ST_OK;
            r.device_ids = {dec_store[3], dec_store[5]};
            w = {dec_store[6], dec_store[7]};
            if (w != esctfd_pkg::NO_DATA_16) begin
                r.electrical_rpm = w * 20'd10;
                r.valid_mask[0]  = 1'b1;
            end
            w = {dec_store[8], dec_store[9]};
            if (w != esctfd_pkg::NO_DATA_16) begin
                r.voltage_centivolts = w;
                r.valid_mask[1]      = 1'b1;
            end
            w = {dec_store[10], dec_store[11]};
            if (w != esctfd_pkg::NO_DATA_16) begin
                r.fet_temp_decidegrees = w;
                r.valid_mask[2]        = 1'b1;
            end
            w = {dec_store[12], dec_store[13]};
            if (w != esctfd_pkg::NO_DATA_16) begin
                r.current_centiamps = w;
                r.valid_mask[3]     = 1'b1;
            end
            w = {dec_store[14], dec_store[15]};
            if (w != esctfd_pkg::NO_DATA_16) begin
                r.bec_temp_decidegrees = w;
                r.valid_mask[4]        = 1'b1;
            end
            if (dec_store[16] != esctfd_pkg::NO_DATA_8) begin
                r.bec_current_deciamps = dec_store[16];
                r.valid_mask[5]        = 1'b1;
            end
            if (dec_store[17] != esctfd_pkg::NO_DATA_8) begin
                r.bec_voltage_centivolts = dec_store[17] * 11'd5;
                r.valid_mask[6]          = 1'b1;
            end
            if (dec_store[18] <= esctfd_pkg::THROTTLE_MAX) begin
                r.throttle_half_percent = dec_store[18];
                r.valid_mask[7]         = 1'b1;
            end
            if (dec_store[19] != esctfd_pkg::NO_DATA_8) begin
                r.power_out_half_percent = dec_store[19];
                r.valid_mask[8]          = 1'b1;
            end
        end
        dec_count = '0;
        dec_crc   = '0;
        pending_reports.push_back(r);
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: every popped word against the oldest pending report
    always @(posedge i_clk) begin
        esctfd_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result word, status %0d", o_status);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                cmp_field("status", want.status, o_status);
                cmp_field("device_ids", want.device_ids, o_device_ids);
                cmp_field("electrical_rpm", want.electrical_rpm, o_electrical_rpm);
                cmp_field("voltage_centivolts", want.voltage_centivolts,
                          o_voltage_centivolts);
                cmp_field("fet_temp_decidegrees", want.fet_temp_decidegrees,
                          o_fet_temp_decidegrees);
                cmp_field("current_centiamps", want.current_centiamps, o_current_centiamps);
                cmp_field("bec_temp_decidegrees", want.bec_temp_decidegrees,
                          o_bec_temp_decidegrees);
                cmp_field("bec_current_deciamps", want.bec_current_deciamps,
                          o_bec_current_deciamps);
                cmp_field("bec_voltage_centivolts", want.bec_voltage_centivolts,
                          o_bec_voltage_centivolts);
                cmp_field("throttle_half_percent", want.throttle_half_percent,
                          o_throttle_half_percent);
                cmp_field("power_out_half_percent", want.power_out_half_percent,
                          o_power_out_half_percent);
                cmp_field("valid_mask", want.valid_mask, o_valid_mask);
            end
        end
    end

    // Receiver: random stalls, plus a counted long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // One word into the decoder; push stays high until the next falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_telemetry(b, last);
        bytes_sent++;
    endtask

    // Send frame_buf plus its CRC, cut or padded to len words
    task automatic send_frame(input int len, input logic bad_crc);
        logic [15:0] c;
        logic [7:0]  b;
        c = 16'h0000;
        for (int k = 0; k < 20; k++) c = crc16_update(c, frame_buf[k]);
        if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
        for (int k = 0; k < len; k++) begin
            if (k < 20) b = frame_buf[k];
            else if (k == 20) b = c[15:8];
            else if (k == 21) b = c[7:0];
            else b = 8'($urandom_range(255));
            send_byte(b, k == len - 1);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idle(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(5) == 0) ? esctfd_pkg::NO_DATA_8 : 8'($urandom_range(255));
    endfunction

    // Well-formed ESC frame with random fields, sentinels now and then
    function automatic void fill_good_frame();
        logic [7:0] hb;
        frame_buf[0] = esctfd_pkg::SYNC_BYTE;
        frame_buf[1] = esctfd_pkg::TYPE_TELEM;
        frame_buf[2] = esctfd_pkg::FRAME_LEN_BYTE;
        frame_buf[3] = 8'($urandom_range(255));
        frame_buf[4] = esctfd_pkg::DEVICE_ESC;
        frame_buf[5] = 8'($urandom_range(255));
        for (int k = 6; k < 16; k += 2) begin
            if ($urandom_range(5) == 0) begin
                frame_buf[k]     = esctfd_pkg::NO_DATA_8;
                frame_buf[k + 1] = esctfd_pkg::NO_DATA_8;
            end else begin
                frame_buf[k]     = 8'($urandom_range(255));
                frame_buf[k + 1] = 8'($urandom_range(255));
            end
        end
        frame_buf[16] = pick_byte();
        frame_buf[17] = pick_byte();
        case ($urandom_range(4))
            0: hb = esctfd_pkg::THROTTLE_MAX;
            1: hb = esctfd_pkg::THROTTLE_MAX + 8'd1;
            2: hb = 8'($urandom_range(255));
            default: hb = 8'($urandom_range(200));
        endcase
        frame_buf[18] = hb;
        frame_buf[19] = pick_byte();
    endfunction

    // Zero, all-missing and largest field values, throttle on both sides of its limit
    task automatic test_field_extremes();
        fill_good_frame();
        for (int k = 3; k < 20; k++) frame_buf[k] = 8'h00;
        frame_buf[4] = esctfd_pkg::DEVICE_ESC;
        send_frame(22, 1'b0);

        for (int k = 3; k < 20; k++) frame_buf[k] = esctfd_pkg::NO_DATA_8;
        frame_buf[4] = esctfd_pkg::DEVICE_ESC;
        send_frame(22, 1'b0);

        for (int k = 3; k < 20; k++) frame_buf[k] = 8'hFE;
        frame_buf[3]  = 8'hFF;
        frame_buf[4]  = esctfd_pkg::DEVICE_ESC;
        frame_buf[5]  = 8'hFF;
        frame_buf[18] = esctfd_pkg::THROTTLE_MAX;
        send_frame(22, 1'b0);

        fill_good_frame();
        frame_buf[18] = esctfd_pkg::THROTTLE_MAX + 8'd1;
        send_frame(22, 1'b0);
    endtask

    // Wrong device and each header or CRC fault
    task automatic test_rejects();
        fill_good_frame();
        frame_buf[4] = esctfd_pkg::DEVICE_ESC + 8'd1;
        send_frame(22, 1'b0);
        for (int k = 0; k < 3; k++) begin
            fill_good_frame();
            frame_buf[k] = frame_buf[k] ^ 8'h01;
            send_frame(22, 1'b0);
        end
        fill_good_frame();
        send_frame(22, 1'b1);
    endtask

    // Short, one-off and overlong frames (counter saturates)
    task automatic test_frame_length();
        fill_good_frame();
        send_frame(1, 1'b0);
        send_frame(21, 1'b0);
        send_frame(23, 1'b0);
        send_frame(40, 1'b0);
        fill_good_frame();
        send_frame(22, 1'b0);
    endtask

    // Mostly valid frames with random content, the rest broken or noise
    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int n_bytes);
        int first_byte;
        int pick;
        int k;
        set_idle(send_pct, stall_pct);
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < n_bytes) begin
            pick = $urandom_range(99);
            fill_good_frame();
            if (pick < 60) begin
                send_frame(22, 1'b0);
            end else if (pick < 68) begin
                frame_buf[4] = esctfd_pkg::DEVICE_ESC ^ 8'($urandom_range(1, 255));
                send_frame(22, 1'b0);
            end else if (pick < 76) begin
                k = $urandom_range(2);
                frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
                send_frame(22, 1'b0);
            end else if (pick < 84) begin
                send_frame(22, 1'b1);
            end else if (pick < 92) begin
                send_frame($urandom_range(1, 21), 1'b0);
            end else if (pick < 97) begin
                send_frame($urandom_range(23, 40), 1'b0);
            end else begin
                for (int j = 0; j < 20; j++) frame_buf[j] = 8'($urandom_range(255));
                send_frame($urandom_range(1, 30), 1'($urandom_range(1)));
            end
        end
        wait_drain();
    endtask

    // Receiver holds off while frames keep coming, so the input must stall
    task automatic test_input_stall();
        set_idle(0, 0);
        hold_left = 400;
        for (int n = 0; n < 6; n++) begin
            fill_good_frame();
            send_frame(22, 1'b0);
        end
        wait_drain();
    endtask

    // Sender pauses until every report is out, then resumes
    task automatic test_drain_pause();
        set_idle(30, 30);
        for (int n = 0; n < 3; n++) begin
            fill_good_frame();
            send_frame(22, 1'b0);
        end
        wait_drain();
        for (int n = 0; n < 3; n++) begin
            fill_good_frame();
            send_frame($urandom_range(20, 23), 1'b0);
        end
        wait_drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(0, 0);
        test_field_extremes();
        test_rejects();
        test_frame_length();
        wait_drain();

        test_random_traffic(0, 0, 170);
        test_random_traffic(82, 0, 170);
        test_random_traffic(0, 82, 170);
        test_random_traffic(11, 11, 170);
        test_input_stall();
        test_drain_pause();

        // Let any stray result show up before the verdict
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("esc_telemetry_frame_decoder test passed");
        else
            $display("esc_telemetry_frame_decoder test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("esc_telemetry_frame_decoder test failed");
        $finish;
    end

endmodule
